// ===== rtl/acctilt_pkg.sv =====
// ----------------------------------------------------------------------------
// acctilt_pkg
// Shared constants, types and the arctangent table for the tilt angle block.
// ----------------------------------------------------------------------------
package acctilt_pkg;

    localparam int ACCEL_WIDTH_DEF       = 12;
    localparam int ANGLE_FRAC_BITS_DEF   = 7;
    localparam int CORDIC_ITERATIONS_DEF = 16;

    localparam int ATAN_TAB_LEN  = 24;
    localparam int ATAN_TAB_W    = 22;
    localparam int INV_GAIN_Q14  = 9949;
    localparam int TRIG_SHIFT    = 14;
    localparam int DEG_SHIFT     = 16;
    localparam int HALF_TURN     = 180 * 65536;
    localparam int HEADING_WIDTH = 9;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cordic_ctl;

    // atan(2^-i) in 2^-16 degree, rounded to nearest.
    function automatic logic [ATAN_TAB_W-1:0] atan_tab(input logic [4:0] idx);
        logic [ATAN_TAB_W-1:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/acctilt_cordic.sv =====
// ----------------------------------------------------------------------------
// acctilt_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module acctilt_cordic
    import acctilt_pkg::*;
#(
    parameter int CW  = 31,
    parameter int AW  = 26,
    parameter int NIT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_ctl          i_ctl,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [AW-1:0] i_ang,
    output logic signed [CW-1:0] o_x,
    output logic signed [AW-1:0] o_ang,
    output logic signed [CW-1:0] o_y,
    output logic                 o_done
);

    localparam int IW = $clog2(NIT);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_rot;
    logic [IW-1:0]        r_it;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [AW-1:0] r_ang;

    logic signed [CW-1:0] s_dx;
    logic signed [CW-1:0] s_dy;
    logic signed [AW-1:0] s_tab;
    logic                 s_sub;

    always_comb begin
        s_dx  = r_y >>> r_it;
        s_dy  = r_x >>> r_it;
        s_tab = signed'(AW'(atan_tab(5'(r_it))));
        // Rotation steers by the residual angle, vectoring by the sign of y.
        s_sub = r_rot ? !r_ang[AW-1] : r_y[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_it   <= '0;
                r_rot  <= i_ctl.rotate;
                r_x    <= i_x;
                r_y    <= i_y;
                r_ang  <= i_ang;
            end else if (r_busy) begin
                if (s_sub) begin
                    r_x   <= r_x - s_dx;
                    r_y   <= r_y + s_dy;
                    r_ang <= r_ang - s_tab;
                end else begin
                    r_x   <= r_x + s_dx;
                    r_y   <= r_y - s_dy;
                    r_ang <= r_ang + s_tab;
                end
                if (r_it == IW'(NIT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_it <= r_it + 1'b1;
                end
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_ang  = r_ang;
    assign o_done = r_done;

endmodule

// ===== rtl/acctilt_isqrt.sv =====
// ----------------------------------------------------------------------------
// acctilt_isqrt
// Bit-serial integer square root, two radicand bits per cycle, floor result.
// ----------------------------------------------------------------------------
module acctilt_isqrt #(
    parameter int SQW = 54
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQW-1:0]     i_val,
    output logic [SQW/2-1:0]   o_root,
    output logic               o_valid
);

    logic           r_busy;
    logic           r_valid;
    logic [SQW-1:0] r_v;
    logic [SQW-1:0] r_res;
    logic [SQW-1:0] r_bit;

    logic [SQW-1:0] s_trial;
    logic           s_ge;

    always_comb begin
        s_trial = r_res + r_bit;
        s_ge    = r_v >= s_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy  <= 1'b1;
                r_valid <= 1'b0;
                r_v     <= i_val;
                r_res   <= '0;
                r_bit   <= {2'b01, {(SQW-2){1'b0}}};
            end else if (r_busy) begin
                if (s_ge) begin
                    r_v   <= r_v - s_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                // The last step is the one that weighs the lowest bit pair.
                if (r_bit[0]) begin
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
            end
        end
    end

    assign o_root  = r_res[SQW/2-1:0];
    assign o_valid = r_valid;

endmodule

// ===== rtl/accel_tilt_angles_with_heading.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles_with_heading
// Roll, pitch and yaw from one accelerometer sample turned by compass heading.
// ----------------------------------------------------------------------------
// One sample is taken at a time; the input is not ready until the sample has
// been worked through. One CORDIC unit runs three passes in turn (sine and
// cosine of the relative heading, the roll arctangent, the pitch arctangent).
// A single multiplier forms the mixed axes and squares in states S_M0 to S_M5.
// A two-bits-per-cycle square root of ACCEL_WIDTH + 15 steps starts with the
// roll pass, and the pitch pass waits for it. The finished angles sit in an
// output register, so a new sample can be accepted while the previous result
// waits to be taken. Angles are in 1/2^ANGLE_FRAC_BITS degree, wrapped to
// [0,360). A sample with zero_button set stores its heading as the new zero,
// so its yaw is zero.
module accel_tilt_angles_with_heading
    import acctilt_pkg::*;
#(
    parameter int ACCEL_WIDTH       = ACCEL_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS   = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // heading[8:0], accel_x, accel_y, accel_z, then zero fill
    input  logic [((HEADING_WIDTH+3*ACCEL_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // zero_button
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
    output logic [47:0]                   m_axis_tdata
);

    localparam int A    = ACCEL_WIDTH;
    localparam int F    = ANGLE_FRAC_BITS;
    localparam int NIT  = (CORDIC_ITERATIONS < ATAN_TAB_LEN) ? CORDIC_ITERATIONS
                                                             : ATAN_TAB_LEN;
    localparam int TW   = 17;
    localparam int MW   = A + 16;
    localparam int CW   = A + 19;
    localparam int AW   = 26;
    localparam int SQW  = 2 * A + 30;
    localparam int SH   = 16 - F;
    localparam int HALF = (1 << SH) >> 1;
    localparam int FULL = 360 << F;
    localparam int YW   = (HEADING_WIDTH + F > 16) ? HEADING_WIDTH + F : 16;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_SC    = 4'd2;
    localparam logic [3:0] S_M0    = 4'd3;
    localparam logic [3:0] S_M1    = 4'd4;
    localparam logic [3:0] S_M2    = 4'd5;
    localparam logic [3:0] S_M3    = 4'd6;
    localparam logic [3:0] S_M4    = 4'd7;
    localparam logic [3:0] S_M5    = 4'd8;
    localparam logic [3:0] S_ROLL  = 4'd9;
    localparam logic [3:0] S_RW    = 4'd10;
    localparam logic [3:0] S_PITCH = 4'd11;
    localparam logic [3:0] S_PW    = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [HEADING_WIDTH-1:0]  r_off;
    logic signed [9:0]         r_phi;
    logic signed [A-1:0]       r_x;
    logic signed [A-1:0]       r_y;
    logic signed [A-1:0]       r_z;
    logic                      r_neg;
    logic [8:0]                r_yaw;
    logic signed [TW-1:0]      r_co;
    logic signed [TW-1:0]      r_si;
    logic signed [MW-1:0]      r_xs;
    logic signed [MW-1:0]      r_ys;
    logic [SQW-1:0]            r_sq;
    logic                      r_zero;
    logic signed [AW-1:0]      r_roll;
    logic signed [AW-1:0]      r_pitch;
    logic                      r_ovalid;
    logic [47:0]               r_odata;

    // Input field views
    logic [HEADING_WIDTH-1:0]  s_head;
    logic signed [A-1:0]       s_ax;
    logic signed [A-1:0]       s_ay;
    logic signed [A-1:0]       s_az;
    logic [HEADING_WIDTH-1:0]  s_off_new;
    logic                      s_in_xfer;
    logic                      s_out_load;

    // Heading reduction and fold
    logic signed [10:0]        s_p1;
    logic signed [10:0]        s_p2;
    logic signed [10:0]        s_p3;
    logic [8:0]                s_pm;
    logic signed [9:0]         s_fold;
    logic                      s_fneg;

    // Shared multiplier
    logic signed [MW-1:0]      s_ma;
    logic signed [MW-1:0]      s_mb;
    logic signed [2*MW-1:0]    s_prod;

    // Arctangent argument preparation
    logic signed [CW-1:0]      s_vx;
    logic signed [CW-1:0]      s_vy;
    logic                      s_pzero;
    logic signed [CW-1:0]      s_px;
    logic signed [CW-1:0]      s_py;
    logic signed [AW-1:0]      s_pacc;

    // CORDIC and square root hookup
    t_cordic_ctl               s_cctl;
    logic signed [CW-1:0]      s_cx;
    logic signed [CW-1:0]      s_cy;
    logic signed [AW-1:0]      s_cang;
    logic signed [CW-1:0]      c_x;
    logic signed [CW-1:0]      c_y;
    logic signed [AW-1:0]      c_ang;
    logic                      c_done;
    logic                      s_sq_start;
    logic [SQW/2-1:0]          q_root;
    logic                      q_valid;

    logic signed [AW-1:0]      s_roll_fin;
    logic [15:0]               s_roll_out;
    logic [15:0]               s_pitch_out;
    logic [YW-1:0]             s_yaw_out;

    function automatic logic [15:0] to_out(input logic signed [AW-1:0] ang);
        logic signed [AW:0] s;
        logic signed [AW:0] r;
        s = AW'(ang) + (AW+1)'(HALF);
        r = s >>> SH;
        if (r < 0) begin
            r = r + (AW+1)'(FULL);
        end
        return r[15:0];
    endfunction

    assign s_head    = s_axis_tdata[HEADING_WIDTH-1:0];
    assign s_ax      = s_axis_tdata[HEADING_WIDTH+A-1:HEADING_WIDTH];
    assign s_ay      = s_axis_tdata[HEADING_WIDTH+2*A-1:HEADING_WIDTH+A];
    assign s_az      = s_axis_tdata[HEADING_WIDTH+3*A-1:HEADING_WIDTH+2*A];
    assign s_off_new = s_axis_tuser ? s_head : r_off;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign s_out_load    = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    // phi lies in [-511,511]; two conditional adds and one subtract bring it
    // into [0,360).
    always_comb begin
        s_p1 = r_phi[9] ? 11'(r_phi) + 11'sd360 : 11'(r_phi);
        s_p2 = s_p1[10] ? s_p1 + 11'sd360 : s_p1;
        s_p3 = (s_p2 >= 11'sd360) ? s_p2 - 11'sd360 : s_p2;
        s_pm = s_p3[8:0];
        if (s_pm > 9'd90 && s_pm <= 9'd270) begin
            s_fold = signed'(10'(s_pm)) - 10'sd180;
            s_fneg = 1'b1;
        end else if (s_pm > 9'd270) begin
            s_fold = signed'(10'(s_pm)) - 10'sd360;
            s_fneg = 1'b0;
        end else begin
            s_fold = signed'(10'(s_pm));
            s_fneg = 1'b0;
        end
    end

    always_comb begin
        s_ma = '0;
        s_mb = '0;
        unique case (r_state)
            S_M0:    begin s_ma = MW'(r_co); s_mb = MW'(r_x); end
            S_M1:    begin s_ma = MW'(r_si); s_mb = MW'(r_y); end
            S_M2:    begin s_ma = MW'(r_si); s_mb = MW'(r_x); end
            S_M3:    begin s_ma = MW'(r_co); s_mb = MW'(r_y); end
            S_M4:    begin s_ma = r_ys;      s_mb = r_ys;     end
            S_M5:    begin
                s_ma = MW'(r_z) <<< TRIG_SHIFT;
                s_mb = MW'(r_z) <<< TRIG_SHIFT;
            end
            default: begin s_ma = '0; s_mb = '0; end
        endcase
        s_prod = s_ma * s_mb;
    end

    // Arguments of atan2(y, x): a negative x is turned by half a turn first.
    always_comb begin
        if (r_state == S_PITCH) begin
            s_vy = CW'(r_xs);
            s_vx = signed'(CW'(q_root));
        end else begin
            s_vy = CW'(r_ys);
            s_vx = -(CW'(r_z) <<< TRIG_SHIFT);
        end
        s_pzero = (s_vx == '0) && (s_vy == '0);
        if (s_vx[CW-1]) begin
            s_px   = -s_vx;
            s_py   = -s_vy;
            s_pacc = s_vy[CW-1] ? -AW'(HALF_TURN) : AW'(HALF_TURN);
        end else begin
            s_px   = s_vx;
            s_py   = s_vy;
            s_pacc = '0;
        end
    end

    always_comb begin
        s_cctl.start  = 1'b0;
        s_cctl.rotate = 1'b0;
        s_cx          = s_px;
        s_cy          = s_py;
        s_cang        = s_pacc;
        priority if (r_state == S_MOD) begin
            s_cctl.start  = 1'b1;
            s_cctl.rotate = 1'b1;
            s_cx          = CW'(INV_GAIN_Q14);
            s_cy          = '0;
            s_cang        = AW'(s_fold) <<< DEG_SHIFT;
        end else if (r_state == S_ROLL) begin
            s_cctl.start = 1'b1;
        end else if (r_state == S_PITCH && q_valid) begin
            s_cctl.start = 1'b1;
        end else begin
            s_cctl.start = 1'b0;
        end
    end

    assign s_sq_start = (r_state == S_ROLL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_in_xfer) begin n_state = S_MOD; end
            S_MOD:   n_state = S_SC;
            S_SC:    if (c_done) begin n_state = S_M0; end
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_ROLL;
            S_ROLL:  n_state = S_RW;
            S_RW:    if (c_done) begin n_state = S_PITCH; end
            S_PITCH: if (q_valid) begin n_state = S_PW; end
            S_PW:    if (c_done) begin n_state = S_OUT; end
            S_OUT:   if (s_out_load) begin n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_roll_fin = r_zero ? '0 : c_ang;
        // Roll is mirrored when the z axis points up.
        if (!r_z[A-1] && (r_z != '0)) begin
            s_roll_fin = -s_roll_fin;
        end
        s_roll_out  = to_out(r_roll);
        s_pitch_out = to_out(r_pitch);
        s_yaw_out   = YW'(r_yaw) << F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_off    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_in_xfer) begin
                r_off <= s_off_new;
            end
            if (s_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_phi <= signed'(10'(s_head)) - signed'(10'(s_off_new));
            r_x   <= s_ax;
            r_y   <= s_ay;
            r_z   <= s_az;
        end
        if (r_state == S_MOD) begin
            r_neg <= s_fneg;
            r_yaw <= (s_pm == 9'd0) ? 9'd0 : 9'd360 - s_pm;
        end
        if (r_state == S_SC && c_done) begin
            r_co <= r_neg ? -TW'(c_x) : TW'(c_x);
            r_si <= r_neg ? -TW'(c_y) : TW'(c_y);
        end
        unique case (r_state)
            S_M0:    r_xs <= s_prod[MW-1:0];
            S_M1:    r_xs <= r_xs + s_prod[MW-1:0];
            S_M2:    r_ys <= s_prod[MW-1:0];
            S_M3:    r_ys <= r_ys + s_prod[MW-1:0];
            S_M4:    r_sq <= s_prod[SQW-1:0];
            S_M5:    r_sq <= r_sq + s_prod[SQW-1:0];
            default: ;
        endcase
        if (r_state == S_ROLL || (r_state == S_PITCH && q_valid)) begin
            r_zero <= s_pzero;
        end
        if (r_state == S_RW && c_done) begin
            r_roll <= s_roll_fin;
        end
        if (r_state == S_PW && c_done) begin
            r_pitch <= r_zero ? '0 : c_ang;
        end
        if (s_out_load) begin
            r_odata <= {s_yaw_out[15:0], s_pitch_out, s_roll_out};
        end
    end

    acctilt_cordic #(
        .CW  (CW),
        .AW  (AW),
        .NIT (NIT)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_cctl),
        .i_x     (s_cx),
        .i_y     (s_cy),
        .i_ang   (s_cang),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_ang   (c_ang),
        .o_done  (c_done)
    );

    acctilt_isqrt #(
        .SQW (SQW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_sq_start),
        .i_val   (r_sq),
        .o_root  (q_root),
        .o_valid (q_valid)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_xfer |=> r_state == S_MOD)
        else $error("sample transfer did not start the sequencer");

    a_cordic_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == S_SC || r_state == S_RW || r_state == S_PW))
        else $error("CORDIC finished while the sequencer was not waiting");

    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_out_load |=> m_axis_tvalid && r_state == S_IDLE)
        else $error("result load did not raise the output valid");

    a_no_start_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sq_start |=> !q_valid)
        else $error("square root result still flagged after a new start");
`endif

endmodule

// ===== sim/accel_tilt_angles_with_heading_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_with_heading_tb
// Self-checking bench for the heading-compensated tilt angle block. Samples
// go in as bursts with random gaps while the result side stalls on its own
// pattern. An in-bench fixed-point model of the CORDIC, square root and
// heading offset predicts roll, pitch and yaw for every accepted sample.
// ----------------------------------------------------------------------------
module accel_tilt_angles_with_heading_tb;
    import acctilt_pkg::*;

    localparam int  AW         = ACCEL_WIDTH_DEF;
    localparam int  FRAC       = ANGLE_FRAC_BITS_DEF;
    localparam int  ITERS      = CORDIC_ITERATIONS_DEF;
    localparam int  DW         = ((HEADING_WIDTH + 3 * AW + 7) / 8) * 8;
    localparam int  CYCLE_CAP  = 2000000;
    localparam longint DEG_ONE = 65536;

    localparam longint ARCTAN_STEP [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
    } t_angles;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;   // heading, accel_x, accel_y, accel_z, zero fill
    logic          s_axis_tuser;   // zero_button
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [47:0]   m_axis_tdata;   // roll, pitch, yaw

    t_angles     angles_pending[$];
    logic [8:0]  zero_heading;
    int          failures = 0;
    int          cycle_count = 0;
    int          stall_pct;
    int          burst_left;
    int          gap_max;

    accel_tilt_angles_with_heading dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Rotation CORDIC for cos/sin in Q14 of a whole-degree angle in [0,360).
    function automatic void heading_trig(input int deg, output longint co,
                                         output longint si);
        longint x, y, ang, dx, dy;
        int     a;
        bit     flip;
        a = deg;
        flip = 1'b0;
        x = INV_GAIN_Q14;
        y = 0;
        if (a > 90 && a <= 270) begin
            a -= 180;
            flip = 1'b1;
        end else if (a > 270) begin
            a -= 360;
        end
        ang = longint'(a) * DEG_ONE;
        for (int i = 0; i < ITERS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x -= dx; y += dy; ang -= ARCTAN_STEP[i];
            end else begin
                x += dx; y -= dy; ang += ARCTAN_STEP[i];
            end
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endfunction

    // Vectoring CORDIC; result in 2^-16 degree.
    function automatic longint vector_angle(input longint yi, input longint xi);
        longint x, y, acc, dx, dy;
        x = xi;
        y = yi;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            acc = (y >= 0) ? 180 * DEG_ONE : -180 * DEG_ONE;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITERS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += ARCTAN_STEP[i];
            end else begin
                x -= dx; y += dy; acc -= ARCTAN_STEP[i];
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] to_units(input longint ang);
        longint full, r;
        full = longint'(360) << FRAC;
        r = ((ang + ((longint'(1) << (16 - FRAC)) >> 1)) >>> (16 - FRAC)) % full;
        if (r < 0) r += full;
        return r[15:0];
    endfunction

    // Updates the stored zero heading and returns the predicted angles.
    function automatic t_angles predict_angles(input logic [8:0] head,
            input logic signed [AW-1:0] ax, input logic signed [AW-1:0] ay,
            input logic signed [AW-1:0] az, input logic btn);
        t_angles r;
        longint  phi, pm, co, si, x, y, z, xs, ys, zq, roll, pitch, yaw;
        longint unsigned ys_mag, zq_mag, rad;
        longint  yaw_units;
        x = ax;
        y = ay;
        z = az;
        if (btn) zero_heading = head;
        phi = longint'(head) - longint'(zero_heading);
        pm = phi % 360;
        if (pm < 0) pm += 360;
        heading_trig(int'(pm), co, si);
        xs = co * x + si * y;
        ys = si * x + co * y;
        zq = z * 16384;
        roll = vector_angle(ys, -zq);
        if (z > 0) roll = -roll;
        ys_mag = (ys < 0) ? -ys : ys;
        zq_mag = (zq < 0) ? -zq : zq;
        rad = int_sqrt(ys_mag * ys_mag + zq_mag * zq_mag);
        pitch = vector_angle(xs, longint'(rad));
        yaw = (-phi) % 360;
        if (yaw < 0) yaw += 360;
        yaw_units = yaw << FRAC;
        r.roll = to_units(roll);
        r.pitch = to_units(pitch);
        r.yaw = yaw_units[15:0];
        return r;
    endfunction

    // Sends one sample; valid stays high into the next sample of a burst.
    task automatic send_sample(input logic [8:0] head, input logic [AW-1:0] ax,
                               input logic [AW-1:0] ay, input logic [AW-1:0] az,
                               input logic btn);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(DW - HEADING_WIDTH - 3 * AW){1'b0}}, az, ay, ax, head};
        s_axis_tuser  <= btn;
        do @(posedge i_clk); while (!s_axis_tready);
        angles_pending.push_back(predict_angles(head, ax, ay, az, btn));
    endtask

    task automatic send_random(input int count, input int btn_pct);
        for (int n = 0; n < count; n++) begin
            send_sample(9'($urandom_range(0, 511)), AW'($urandom), AW'($urandom),
                        AW'($urandom), $urandom_range(0, 99) < btn_pct);
        end
    endtask

    task automatic test_directed();
        stall_pct = 0;
        gap_max = 0;
        send_sample(9'd0, 12'h000, 12'h000, 12'h000, 1'b0);   // all zero: atan2(0,0)
        send_sample(9'd359, 12'h7FF, 12'h7FF, 12'h7FF, 1'b0);
        send_sample(9'd511, 12'h800, 12'h800, 12'h800, 1'b0); // heading past 359
        send_sample(9'd90, 12'h7FF, 12'h800, 12'h001, 1'b0);
        send_sample(9'd180, 12'h800, 12'h7FF, 12'hFFF, 1'b0);
        send_sample(9'd270, 12'h000, 12'h3E8, 12'h000, 1'b0); // z zero
        send_sample(9'd271, 12'h000, 12'hC18, 12'h000, 1'b0); // z zero, ys negative
        send_sample(9'd120, 12'h100, 12'h200, 12'hC00, 1'b1); // capture offset
        send_sample(9'd30, 12'h100, 12'h200, 12'h400, 1'b0);  // phi negative
        send_sample(9'd500, 12'h555, 12'hAAA, 12'h3E8, 1'b0);
        send_sample(9'd511, 12'h555, 12'hAAA, 12'hC18, 1'b1);
        send_sample(9'd0, 12'h000, 12'h000, 12'h3E8, 1'b0);
        send_sample(9'd256, 12'h7FF, 12'h000, 12'h000, 1'b0);
        send_sample(9'd0, 12'h000, 12'h000, 12'h000, 1'b1);
        send_sample(9'd45, 12'h800, 12'h000, 12'h000, 1'b0);
        send_sample(9'd91, 12'h3E8, 12'h3E8, 12'h3E8, 1'b0);
        send_sample(9'd269, 12'hC18, 12'hC18, 12'hC18, 1'b0);
    endtask

    task automatic test_bursts_with_stalls();
        stall_pct = 40;
        gap_max = 20;
        send_random(600, 10);
    endtask

    task automatic test_back_to_back();
        stall_pct = 0;
        gap_max = 0;
        send_random(300, 5);
    endtask

    task automatic test_slow_receiver();
        stall_pct = 90;
        gap_max = 4;
        send_random(300, 20);
    endtask

    task automatic test_mixed_pace();
        for (int k = 0; k < 8; k++) begin
            stall_pct = $urandom_range(0, 95);
            gap_max = $urandom_range(0, 80);
            send_random(50, 15);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (angles_pending.size() == 0) begin
                $error("result transfer with no sample outstanding: %h", m_axis_tdata);
                failures++;
            end else begin
                want = angles_pending.pop_front();
                if (m_axis_tdata[15:0] !== want.roll) begin
                    $error("roll_angle expected %0d actual %0d", want.roll,
                           m_axis_tdata[15:0]);
                    failures++;
                end
                if (m_axis_tdata[31:16] !== want.pitch) begin
                    $error("pitch_angle expected %0d actual %0d", want.pitch,
                           m_axis_tdata[31:16]);
                    failures++;
                end
                if (m_axis_tdata[47:32] !== want.yaw) begin
                    $error("yaw_angle expected %0d actual %0d", want.yaw,
                           m_axis_tdata[47:32]);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int drain;
        zero_heading  = '0;
        stall_pct     = 0;
        burst_left    = 0;
        gap_max       = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_bursts_with_stalls();
        test_back_to_back();
        test_slow_receiver();
        test_mixed_pace();

        s_axis_tvalid <= 1'b0;
        stall_pct = 30;
        drain = 0;
        while (angles_pending.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        if (angles_pending.size() != 0) begin
            $error("%0d results never arrived", angles_pending.size());
        end
        // Anything extra the block emits after this point is caught by the checker.
        repeat (200) @(posedge i_clk);
        if (failures == 0 && angles_pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
